// File: src/sbcr_pkg.sv
// Shared types, command codes and helpers for the sphere/box collision resolver.
// Used by sbcr_ctrl, sbcr_dp and the top level.
package sbcr_pkg;

  // Register addresses (word index taken from paddr[2])
  localparam logic RegRadius = 1'b0;
  localparam logic RegLift   = 1'b1;

  localparam logic [30:0] RadiusRst = 31'd32768;
  localparam logic [15:0] LiftRst   = 16'd7;

  localparam int unsigned SqrtIters = 32;
  localparam int unsigned DivIters  = 17;

  // Datapath operations
  typedef enum logic [4:0] {
    OP_NONE,
    OP_LOAD,
    OP_GROUND,
    OP_MUL_SQ,
    OP_ACC_SQ,
    OP_MUL_R2,
    OP_MISS,
    OP_SQRT_INIT,
    OP_SQRT_STEP,
    OP_DIV_INIT,
    OP_DIV_STEP,
    OP_DIV_END,
    OP_NORM_UP,
    OP_MUL_PUSH,
    OP_ADD_PUSH,
    OP_MUL_DOT,
    OP_ACC_DOT,
    OP_MUL_VEL,
    OP_ADD_VEL,
    OP_BOX_END,
    OP_OUT
  } op_e;

  typedef struct packed {
    op_e        op;
    logic [1:0] axis;
  } cmd_t;

  typedef struct packed {
    logic hit;
    logic dist_zero;
    logic vn_neg;
    logic out_busy;
  } sts_t;

  // Saturate a signed value to the 32-bit range
  function automatic logic signed [31:0] sat32(input logic signed [37:0] v);
    logic signed [31:0] r;
    if (v > 38'sh007FFFFFFF) r = 32'sh7FFFFFFF;
    else if (v < -38'sh0080000000) r = 32'sh80000000;
    else r = v[31:0];
    return r;
  endfunction

endpackage

// File: src/sphere_box_collision_resolver_unit.sv
// Top level of the sphere/box collision resolver: APB registers, sequencer
// and datapath. Depends on sbcr_pkg, sbcr_ctrl, sbcr_dp.
//
// Usage:
//  - Slave stream (s_*) takes one request per item. s_tuser is the action:
//    0 loads center/velocity and resolves against the ground plane y=0,
//    1 resolves the stored sphere against the box in s_tdata.
//  - Master stream (m_*) returns exactly one result per request: resolved
//    center and velocity in m_tdata, contact and grounded flags in m_tuser.
//  - One item at a time. A load passes the ground step before its result
//    is registered. A box miss passes the squared-distance and compare steps;
//    a hit adds the 32-step square root, three normal divisions (17 quotient
//    bits plus setup and sign) and the multiply passes, with more of them when
//    inward velocity is removed; a center inside the box skips the divisions.
//    The iterative root and divider dominate the time of a hit.
//  - The result sits in an output register, so s_tready returns high while
//    a result waits; a stalled receiver holds the next finished item in
//    its last step until the output register drains.
//  - Reset clears the sphere state, grounded flag and handshake state and
//    loads radius 0.5 and lift threshold 7 (Q16.16).
//  - Registers (APB, write while idle): 0x0 radius[30:0], 0x4 lift[15:0].
module sphere_box_collision_resolver_unit import sbcr_pkg::*; (
  input  logic         clk_i,
  input  logic         rst_ni,
  // APB config port
  input  logic         psel,
  input  logic         penable,
  input  logic         pwrite,
  input  logic [2:0]   paddr,
  input  logic [31:0]  pwdata,
  output logic [31:0]  prdata,
  output logic         pready,
  // request stream
  input  logic         s_tvalid,
  output logic         s_tready,
  // first_x, first_y, first_z, second_x, second_y, second_z (32 bits each)
  input  logic [191:0] s_tdata,
  // action
  input  logic         s_tuser,
  // result stream
  output logic         m_tvalid,
  input  logic         m_tready,
  // out_center_x/y/z, out_vel_x/y/z (32 bits each)
  output logic [191:0] m_tdata,
  // contact, grounded
  output logic [1:0]   m_tuser
);

  logic [30:0] radius_q;
  logic [15:0] lift_q;
  logic        cfg_wr;
  cmd_t        cmd;
  sts_t        sts;

  // register file; only paddr[2] decodes the register
  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      radius_q <= RadiusRst;
      lift_q   <= LiftRst;
    end else if (cfg_wr) begin
      if (paddr[2] == RegRadius) radius_q <= pwdata[30:0];
      else lift_q <= pwdata[15:0];
    end
  end

  assign prdata = (paddr[2] == RegRadius) ? {1'b0, radius_q} : {16'b0, lift_q};

  sbcr_ctrl u_ctrl (
    .clk_i,
    .rst_ni,
    .s_valid_i (s_tvalid),
    .action_i  (s_tuser),
    .s_ready_o (s_tready),
    .sts_i     (sts),
    .cmd_o     (cmd)
  );

  sbcr_dp u_dp (
    .clk_i,
    .rst_ni,
    .cmd_i       (cmd),
    .action_i    (s_tuser),
    .in_data_i   (s_tdata),
    .radius_i    (radius_q),
    .lift_i      (lift_q),
    .sts_o       (sts),
    .out_valid_o (m_tvalid),
    .out_ready_i (m_tready),
    .out_data_o  (m_tdata),
    .out_user_o  (m_tuser)
  );

endmodule

// File: src/sbcr_ctrl.sv
// Sequencer for the collision resolver: walks one item through the datapath.
// Depends on sbcr_pkg.
module sbcr_ctrl import sbcr_pkg::*; (
  input  logic clk_i,
  input  logic rst_ni,
  input  logic s_valid_i,
  input  logic action_i,
  output logic s_ready_o,
  input  sts_t sts_i,
  output cmd_t cmd_o
);

  typedef enum logic [21:0] {
    S_IDLE      = 22'h000001,
    S_GROUND    = 22'h000002,
    S_SQ_MUL    = 22'h000004,
    S_SQ_ACC    = 22'h000008,
    S_R2_MUL    = 22'h000010,
    S_CMP       = 22'h000020,
    S_MISS      = 22'h000040,
    S_SQRT_INIT = 22'h000080,
    S_SQRT      = 22'h000100,
    S_DIV_INIT  = 22'h000200,
    S_DIV       = 22'h000400,
    S_DIV_END   = 22'h000800,
    S_NORM_UP   = 22'h001000,
    S_PUSH_MUL  = 22'h002000,
    S_PUSH_ADD  = 22'h004000,
    S_DOT_MUL   = 22'h008000,
    S_DOT_ACC   = 22'h010000,
    S_VN        = 22'h020000,
    S_VEL_MUL   = 22'h040000,
    S_VEL_ADD   = 22'h080000,
    S_BOX_END   = 22'h100000,
    S_OUT       = 22'h200000
  } state_e;

  state_e     state_q, state_d;
  logic [1:0] axis_q, axis_d;
  logic [4:0] cnt_q, cnt_d;
  op_e        op;

  assign s_ready_o = (state_q == S_IDLE);
  assign cmd_o.op   = op;
  assign cmd_o.axis = axis_q;

  always_comb begin
    state_d = state_q;
    axis_d  = axis_q;
    cnt_d   = cnt_q;
    op      = OP_NONE;
    case (state_q)
      S_IDLE: begin
        if (s_valid_i) begin
          op     = OP_LOAD;
          axis_d = 2'd0;
          state_d = action_i ? S_SQ_MUL : S_GROUND;
        end
      end
      S_GROUND: begin
        op = OP_GROUND;
        state_d = S_OUT;
      end
      S_SQ_MUL: begin
        op = OP_MUL_SQ;
        state_d = S_SQ_ACC;
      end
      S_SQ_ACC: begin
        op = OP_ACC_SQ;
        if (axis_q == 2'd2) begin
          state_d = S_R2_MUL;
        end else begin
          axis_d = axis_q + 2'd1;
          state_d = S_SQ_MUL;
        end
      end
      S_R2_MUL: begin
        op = OP_MUL_R2;
        state_d = S_CMP;
      end
      S_CMP: begin
        state_d = sts_i.hit ? S_SQRT_INIT : S_MISS;
      end
      S_MISS: begin
        op = OP_MISS;
        state_d = S_OUT;
      end
      S_SQRT_INIT: begin
        op = OP_SQRT_INIT;
        cnt_d = '0;
        state_d = S_SQRT;
      end
      S_SQRT: begin
        op = OP_SQRT_STEP;
        if (cnt_q == 5'(SqrtIters - 1)) begin
          axis_d = 2'd0;
          state_d = S_DIV_INIT;
        end else begin
          cnt_d = cnt_q + 5'd1;
        end
      end
      S_DIV_INIT: begin
        if (sts_i.dist_zero) begin
          state_d = S_NORM_UP;
        end else begin
          op = OP_DIV_INIT;
          cnt_d = '0;
          state_d = S_DIV;
        end
      end
      S_DIV: begin
        op = OP_DIV_STEP;
        if (cnt_q == 5'(DivIters - 1)) state_d = S_DIV_END;
        else cnt_d = cnt_q + 5'd1;
      end
      S_DIV_END: begin
        op = OP_DIV_END;
        if (axis_q == 2'd2) begin
          axis_d = 2'd0;
          state_d = S_PUSH_MUL;
        end else begin
          axis_d = axis_q + 2'd1;
          state_d = S_DIV_INIT;
        end
      end
      S_NORM_UP: begin
        op = OP_NORM_UP;
        axis_d = 2'd0;
        state_d = S_PUSH_MUL;
      end
      S_PUSH_MUL: begin
        op = OP_MUL_PUSH;
        state_d = S_PUSH_ADD;
      end
      S_PUSH_ADD: begin
        op = OP_ADD_PUSH;
        if (axis_q == 2'd2) begin
          axis_d = 2'd0;
          state_d = S_DOT_MUL;
        end else begin
          axis_d = axis_q + 2'd1;
          state_d = S_PUSH_MUL;
        end
      end
      S_DOT_MUL: begin
        op = OP_MUL_DOT;
        state_d = S_DOT_ACC;
      end
      S_DOT_ACC: begin
        op = OP_ACC_DOT;
        if (axis_q == 2'd2) begin
          axis_d = 2'd0;
          state_d = S_VN;
        end else begin
          axis_d = axis_q + 2'd1;
          state_d = S_DOT_MUL;
        end
      end
      S_VN: begin
        state_d = sts_i.vn_neg ? S_VEL_MUL : S_BOX_END;
      end
      S_VEL_MUL: begin
        op = OP_MUL_VEL;
        state_d = S_VEL_ADD;
      end
      S_VEL_ADD: begin
        op = OP_ADD_VEL;
        if (axis_q == 2'd2) begin
          state_d = S_BOX_END;
        end else begin
          axis_d = axis_q + 2'd1;
          state_d = S_VEL_MUL;
        end
      end
      S_BOX_END: begin
        op = OP_BOX_END;
        state_d = S_OUT;
      end
      S_OUT: begin
        if (!sts_i.out_busy) begin
          op = OP_OUT;
          state_d = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      axis_q  <= '0;
      cnt_q   <= '0;
    end else begin
      state_q <= state_d;
      axis_q  <= axis_d;
      cnt_q   <= cnt_d;
    end
  end

endmodule

// File: src/sbcr_dp.sv
// Datapath of the collision resolver: sphere state, shared multiplier,
// bit-serial square root and divider, output register. Depends on sbcr_pkg.
module sbcr_dp import sbcr_pkg::*; (
  input  logic         clk_i,
  input  logic         rst_ni,
  input  cmd_t         cmd_i,
  input  logic         action_i,
  input  logic [191:0] in_data_i,
  input  logic [30:0]  radius_i,
  input  logic [15:0]  lift_i,
  output sts_t         sts_o,
  output logic         out_valid_o,
  input  logic         out_ready_i,
  output logic [191:0] out_data_o,
  output logic [1:0]   out_user_o
);

  logic signed [31:0] cen_q [3];
  logic signed [31:0] vel_q [3];
  logic signed [32:0] d_q [3];
  logic signed [17:0] n_q [3];
  logic signed [31:0] oldy_q;
  logic [63:0]        dist2_q;
  logic signed [68:0] prod_q;
  logic [63:0]        sx_q, sres_q, sbit_q;
  logic [30:0]        rem_q;
  logic [16:0]        sh_q, quo_q;
  logic signed [49:0] dot_q;
  logic               grounded_q, contact_q;
  logic               out_valid_q;
  logic [191:0]       out_data_q;
  logic [1:0]         out_user_q;

  logic [1:0]         ax;
  logic signed [32:0] d_sel;
  logic [31:0]        mag_sel;
  logic [30:0]        root;
  logic [30:0]        pen;
  logic [49:0]        dot_mag;
  logic [33:0]        vn_abs;
  logic signed [34:0] vn;
  logic signed [32:0] mul_a;
  logic signed [35:0] mul_b;
  logic [68:0]        prod_mag;
  logic [36:0]        mq_abs;
  logic signed [37:0] mq;
  logic [64:0]        sq_sum;
  logic [63:0]        s_trial;
  logic [31:0]        div_t;
  logic               div_ge;
  logic signed [31:0] in_a [3];
  logic signed [31:0] in_b [3];
  logic signed [31:0] clamp [3];

  assign ax      = cmd_i.axis;
  assign d_sel   = d_q[ax];
  assign mag_sel = d_sel[32] ? 32'(-d_sel) : d_sel[31:0];
  assign root    = sres_q[30:0];
  assign pen     = radius_i - root;

  assign dot_mag = dot_q[49] ? 50'(-dot_q) : 50'(dot_q);
  assign vn_abs  = dot_mag[49:16];
  assign vn      = dot_q[49] ? -$signed({1'b0, vn_abs}) : $signed({1'b0, vn_abs});

  assign prod_mag = prod_q[68] ? 69'(-prod_q) : 69'(prod_q);
  assign mq_abs   = prod_mag[52:16];
  assign mq       = prod_q[68] ? -$signed({1'b0, mq_abs}) : $signed({1'b0, mq_abs});

  assign sq_sum  = {1'b0, dist2_q} + {1'b0, prod_q[63:0]};
  assign s_trial = sres_q + sbit_q;
  assign div_t   = {rem_q, sh_q[16]};
  assign div_ge  = div_t >= {1'b0, root};

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      in_a[i] = in_data_i[32*i +: 32];
      in_b[i] = in_data_i[96 + 32*i +: 32];
      if (cen_q[i] < in_a[i]) clamp[i] = in_a[i];
      else if (cen_q[i] > in_b[i]) clamp[i] = in_b[i];
      else clamp[i] = cen_q[i];
    end
  end

  // shared multiplier operand select
  always_comb begin
    mul_a = '0;
    mul_b = '0;
    case (cmd_i.op)
      OP_MUL_SQ: begin
        mul_a = {1'b0, mag_sel};
        mul_b = {4'b0, mag_sel};
      end
      OP_MUL_R2: begin
        mul_a = {2'b0, radius_i};
        mul_b = {5'b0, radius_i};
      end
      OP_MUL_PUSH: begin
        mul_a = 33'(n_q[ax]);
        mul_b = {5'b0, pen};
      end
      OP_MUL_DOT: begin
        mul_a = 33'(n_q[ax]);
        mul_b = 36'(vel_q[ax]);
      end
      OP_MUL_VEL: begin
        mul_a = 33'(n_q[ax]);
        mul_b = 36'(vn);
      end
      default: begin
        mul_a = '0;
      end
    endcase
  end

  assign sts_o.hit       = dist2_q <= prod_q[63:0];
  assign sts_o.dist_zero = (sres_q == '0);
  assign sts_o.vn_neg    = vn[34];
  assign sts_o.out_busy  = out_valid_q;

  always_ff @(posedge clk_i) begin
    case (cmd_i.op)
      OP_LOAD: begin
        dist2_q <= '0;
        dot_q   <= '0;
        oldy_q  <= cen_q[1];
        for (int i = 0; i < 3; i++) begin
          d_q[i] <= 33'(cen_q[i]) - 33'(clamp[i]);
        end
      end
      OP_MUL_SQ, OP_MUL_R2, OP_MUL_PUSH, OP_MUL_DOT, OP_MUL_VEL: begin
        prod_q <= mul_a * mul_b;
      end
      OP_ACC_SQ: begin
        dist2_q <= sq_sum[64] ? '1 : sq_sum[63:0];
      end
      OP_SQRT_INIT: begin
        sx_q   <= dist2_q;
        sres_q <= '0;
        sbit_q <= 64'h4000_0000_0000_0000;
      end
      OP_SQRT_STEP: begin
        if (sx_q >= s_trial) begin
          sx_q   <= sx_q - s_trial;
          sres_q <= (sres_q >> 1) + sbit_q;
        end else begin
          sres_q <= sres_q >> 1;
        end
        sbit_q <= sbit_q >> 2;
      end
      OP_DIV_INIT: begin
        rem_q <= mag_sel[31:1];
        sh_q  <= {mag_sel[0], 16'b0};
        quo_q <= '0;
      end
      OP_DIV_STEP: begin
        rem_q <= div_ge ? 31'(div_t - {1'b0, root}) : div_t[30:0];
        sh_q  <= sh_q << 1;
        quo_q <= {quo_q[15:0], div_ge};
      end
      OP_DIV_END: begin
        n_q[ax] <= d_sel[32] ? -$signed({1'b0, quo_q}) : $signed({1'b0, quo_q});
      end
      OP_NORM_UP: begin
        n_q[0] <= '0;
        n_q[1] <= 18'sd65536;
        n_q[2] <= '0;
      end
      OP_ACC_DOT: begin
        dot_q <= dot_q + prod_q[49:0];
      end
      default: begin
        prod_q <= prod_q;
      end
    endcase
  end

  // architectural state, output register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < 3; i++) begin
        cen_q[i] <= '0;
        vel_q[i] <= '0;
      end
      grounded_q  <= 1'b0;
      contact_q   <= 1'b0;
      out_valid_q <= 1'b0;
      out_data_q  <= '0;
      out_user_q  <= '0;
    end else begin
      if (out_valid_q && out_ready_i) out_valid_q <= 1'b0;
      case (cmd_i.op)
        OP_LOAD: begin
          if (!action_i) begin
            for (int i = 0; i < 3; i++) begin
              cen_q[i] <= in_a[i];
              vel_q[i] <= in_b[i];
            end
          end
        end
        OP_GROUND: begin
          if ($signed({cen_q[1][31], cen_q[1]}) < $signed({2'b0, radius_i})) begin
            cen_q[1] <= {1'b0, radius_i};
            if (vel_q[1][31]) vel_q[1] <= '0;
            contact_q  <= 1'b1;
            grounded_q <= 1'b1;
          end else begin
            contact_q  <= 1'b0;
            grounded_q <= 1'b0;
          end
        end
        OP_MISS: contact_q <= 1'b0;
        OP_ADD_PUSH: cen_q[ax] <= sat32(38'(cen_q[ax]) + mq);
        OP_ADD_VEL:  vel_q[ax] <= sat32(38'(vel_q[ax]) - mq);
        OP_BOX_END: begin
          contact_q <= 1'b1;
          if (34'(cen_q[1]) > 34'(oldy_q) + $signed({18'b0, lift_i})) grounded_q <= 1'b1;
        end
        OP_OUT: begin
          out_valid_q <= 1'b1;
          out_data_q  <= {vel_q[2], vel_q[1], vel_q[0], cen_q[2], cen_q[1], cen_q[0]};
          out_user_q  <= {grounded_q, contact_q};
        end
        default: begin
          contact_q <= contact_q;
        end
      endcase
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_data_q;
  assign out_user_o  = out_user_q;

endmodule

// File: src/sbcr_checker.sv
// Port-level checks for the collision resolver top level, with its bind.
// Depends on sphere_box_collision_resolver_unit.
module sbcr_checker (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        psel,
  input logic        penable,
  input logic        pwrite,
  input logic [2:0]  paddr,
  input logic [31:0] pwdata,
  input logic [31:0] prdata,
  input logic        s_tvalid,
  input logic        s_tready,
  input logic        m_tvalid,
  input logic        m_tready
);

  // stalled result stays offered
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_tvalid && !m_tready |=> m_tvalid)
    else $error("result dropped while stalled");

  // one request in flight: ready drops right after accept
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    s_tvalid && s_tready |=> !s_tready)
    else $error("request accepted while busy");

  // a new result appears as the sequencer returns to idle
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(m_tvalid) |-> s_tready)
    else $error("result issued outside of finish step");

  // radius readback follows the last write
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    psel && penable && pwrite && !paddr[2]
    |=> paddr[2] || prdata == {1'b0, $past(pwdata[30:0])})
    else $error("radius readback mismatch");

  // result register empty under reset
  assert property (@(posedge clk_i) !rst_ni |-> !m_tvalid)
    else $error("result valid during reset");

endmodule

bind sphere_box_collision_resolver_unit sbcr_checker u_sbcr_checker (
  .clk_i,
  .rst_ni,
  .psel,
  .penable,
  .pwrite,
  .paddr,
  .pwdata,
  .prdata,
  .s_tvalid,
  .s_tready,
  .m_tvalid,
  .m_tready
);

// File: bench/testbench.sv
// Self-checking bench for sphere_box_collision_resolver_unit: random and directed
// load/box requests, a local Q16.16 predictor and a stream scoreboard.
// Depends on sbcr_pkg and the RTL of the resolver.
`timescale 1ns / 100ps

module testbench;
  import sbcr_pkg::*;

  localparam int unsigned WatchdogLimit = 20000;
  localparam int unsigned DrainCycles   = 200;
  localparam int unsigned HoldCycles    = 400;
  localparam logic ActLoad = 1'b0;
  localparam logic ActBox  = 1'b1;
  localparam longint QOne  = 65536;
  localparam logic [2:0] AddrRadius = 3'd0;
  localparam logic [2:0] AddrLift   = 3'd4;

  typedef struct packed {
    logic             action;
    logic [2:0][31:0] first;   // center on load, box min otherwise
    logic [2:0][31:0] second;  // velocity on load, box max otherwise
  } request_t;

  typedef struct packed {
    logic [2:0][31:0] ctr;
    logic [2:0][31:0] vel;
    logic             contact;
    logic             grounded;
  } sphere_state_t;

  logic clk_i, rst_ni;
  logic psel, penable, pwrite, pready;
  logic [2:0] paddr;
  logic [31:0] pwdata, prdata;
  logic s_tvalid, s_tready, s_tuser;
  logic [191:0] s_tdata;
  logic m_tvalid, m_tready;
  logic [191:0] m_tdata;
  logic [1:0] m_tuser;

  sphere_box_collision_resolver_unit u_top (
    .clk_i, .rst_ni, .psel, .penable, .pwrite, .paddr, .pwdata, .prdata, .pready,
    .s_tvalid, .s_tready, .s_tdata, .s_tuser,
    .m_tvalid, .m_tready, .m_tdata, .m_tuser
  );

  // predictor state
  longint sph_ctr[3], sph_vel[3];
  bit     sph_grounded;
  longint radius_q = 32768, lift_q = 7;

  request_t      pending_requests[$];
  sphere_state_t expected_states[$];
  int  errors, n_loads, n_boxes, n_hits, n_results;
  bit  quiet;
  int unsigned idle_cycles;

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  function automatic longint sat32(longint v);
    if (v > 64'sd2147483647) return 64'sd2147483647;
    if (v < -64'sd2147483648) return -64'sd2147483648;
    return v;
  endfunction

  function automatic longint unsigned isqrt(longint unsigned x);
    longint unsigned res, bitv;
    res = 0;
    bitv = 64'd1 << 62;
    while (bitv > x) bitv >>= 2;
    while (bitv != 0) begin
      if (x >= res + bitv) begin
        x -= res + bitv;
        res = (res >> 1) + bitv;
      end else begin
        res >>= 1;
      end
      bitv >>= 2;
    end
    return res;
  endfunction

  // Advances the local sphere state by one request and returns its result.
  function automatic sphere_state_t resolve_sphere(request_t q);
    longint lo[3], hi[3], d[3], nrm[3], cl, dot, vn, pen, old_y;
    longint unsigned m, sq, dist2, root;
    bit hit;
    sphere_state_t res;
    for (int i = 0; i < 3; i++) begin
      lo[i] = longint'($signed(q.first[i]));
      hi[i] = longint'($signed(q.second[i]));
    end
    if (q.action == ActLoad) begin
      for (int i = 0; i < 3; i++) begin
        sph_ctr[i] = lo[i];
        sph_vel[i] = hi[i];
      end
      hit = (sph_ctr[1] - radius_q) < 0;
      if (hit) begin
        sph_ctr[1] = radius_q;
        if (sph_vel[1] < 0) sph_vel[1] = 0;
      end
      sph_grounded = hit;
    end else begin
      old_y = sph_ctr[1];
      dist2 = 0;
      for (int i = 0; i < 3; i++) begin
        // minimum tested first, so an inverted box clamps as written
        cl = sph_ctr[i] < lo[i] ? lo[i] : (sph_ctr[i] > hi[i] ? hi[i] : sph_ctr[i]);
        d[i] = sph_ctr[i] - cl;
        m = d[i] < 0 ? -d[i] : d[i];
        sq = m * m;
        dist2 = (dist2 > 64'hFFFF_FFFF_FFFF_FFFF - sq) ? 64'hFFFF_FFFF_FFFF_FFFF
                                                       : dist2 + sq;
      end
      hit = dist2 <= longint'(radius_q * radius_q);
      if (hit) begin
        root = isqrt(dist2);
        pen = radius_q - longint'(root);
        if (root > 0) begin
          for (int i = 0; i < 3; i++) begin
            m = d[i] < 0 ? -d[i] : d[i];
            nrm[i] = longint'((m << 16) / root);
            if (d[i] < 0) nrm[i] = -nrm[i];
          end
        end else begin
          // center inside the box: push straight up
          nrm[0] = 0; nrm[1] = QOne; nrm[2] = 0;
        end
        dot = 0;
        for (int i = 0; i < 3; i++) sph_ctr[i] = sat32(sph_ctr[i] + (nrm[i] * pen) / QOne);
        for (int i = 0; i < 3; i++) dot += sph_vel[i] * nrm[i];
        vn = dot / QOne;
        if (vn < 0)
          for (int i = 0; i < 3; i++) sph_vel[i] = sat32(sph_vel[i] - (nrm[i] * vn) / QOne);
        if (sph_ctr[1] > old_y + lift_q) sph_grounded = 1'b1;
        n_hits++;
      end
    end
    for (int i = 0; i < 3; i++) begin
      res.ctr[i] = sph_ctr[i][31:0];
      res.vel[i] = sph_vel[i][31:0];
    end
    res.contact = hit;
    res.grounded = sph_grounded;
    return res;
  endfunction

  // Stream driver: offers queued requests, random idle bursts.
  int unsigned send_gap;
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s_tvalid <= 1'b0;
      s_tdata  <= '0;
      s_tuser  <= 1'b0;
      send_gap = 0;
    end else begin
      logic next_valid;
      request_t head;
      if (s_tvalid && s_tready) begin
        expected_states.push_back(resolve_sphere(pending_requests.pop_front()));
        if (!quiet && $urandom_range(0, 5) == 0) send_gap = $urandom_range(1, 8);
      end
      next_valid = 1'b0;
      if (send_gap > 0) send_gap--;
      else if (pending_requests.size() > 0) next_valid = 1'b1;
      s_tvalid <= next_valid;
      if (next_valid) begin
        head = pending_requests[0];
        s_tdata <= {head.second, head.first};
        s_tuser <= head.action;
      end
    end
  end

  // Result monitor with random back-pressure and one long hold.
  int unsigned recv_gap;
  bit held_once;
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      m_tready <= 1'b0;
      recv_gap = 0;
      held_once = 0;
    end else begin
      if (m_tvalid && m_tready) begin
        sphere_state_t exp_s;
        if (expected_states.size() == 0) begin
          $error("result with no request outstanding");
          errors++;
        end else begin
          exp_s = expected_states.pop_front();
          for (int i = 0; i < 3; i++) begin
            if (m_tdata[32*i +: 32] !== exp_s.ctr[i]) begin
              $error("out_center[%0d] exp %h got %h", i, exp_s.ctr[i], m_tdata[32*i +: 32]);
              errors++;
            end
            if (m_tdata[96 + 32*i +: 32] !== exp_s.vel[i]) begin
              $error("out_vel[%0d] exp %h got %h", i, exp_s.vel[i], m_tdata[96 + 32*i +: 32]);
              errors++;
            end
          end
          if (m_tuser[0] !== exp_s.contact) begin
            $error("contact exp %b got %b", exp_s.contact, m_tuser[0]);
            errors++;
          end
          if (m_tuser[1] !== exp_s.grounded) begin
            $error("grounded exp %b got %b", exp_s.grounded, m_tuser[1]);
            errors++;
          end
        end
        n_results++;
        if (n_results == 40 && !held_once) begin
          // long hold so the block backs up and stalls its input
          recv_gap = HoldCycles;
          held_once = 1;
        end else if (!quiet && $urandom_range(0, 5) == 0) begin
          recv_gap = $urandom_range(1, 8);
        end
      end
      if (recv_gap > 0) begin
        recv_gap--;
        m_tready <= 1'b0;
      end else begin
        m_tready <= 1'b1;
      end
    end
  end

  // Watchdog: cycles with nothing accepted on either stream.
  always @(posedge clk_i) begin
    if ((s_tvalid && s_tready) || (m_tvalid && m_tready) || !rst_ni) idle_cycles <= 0;
    else idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= WatchdogLimit) begin
      $display("timeout: %0d pending, %0d expected",
               pending_requests.size(), expected_states.size());
      $display("status: fail");
      $finish;
    end
  end

  task automatic reg_write(input logic [2:0] addr, input logic [31:0] data);
    @(posedge clk_i);
    psel <= 1'b1; pwrite <= 1'b1; penable <= 1'b0; paddr <= addr; pwdata <= data;
    @(posedge clk_i);
    penable <= 1'b1;
    @(posedge clk_i);
    psel <= 1'b0; penable <= 1'b0; pwrite <= 1'b0;
    if (addr == AddrRadius) radius_q = longint'(data & 32'h7FFF_FFFF);
    else if (addr == AddrLift) lift_q = longint'(data & 32'h0000_FFFF);
  endtask

  task automatic push_request(input logic act, input longint f[3], input longint s[3]);
    request_t q;
    q.action = act;
    for (int i = 0; i < 3; i++) begin
      q.first[i]  = 32'(sat32(f[i]));
      q.second[i] = 32'(sat32(s[i]));
    end
    pending_requests.push_back(q);
    if (act == ActLoad) n_loads++; else n_boxes++;
  endtask

  function automatic longint rand32();
    return longint'($signed($urandom()));
  endfunction

  // A load near the origin, then a run of boxes placed around it.
  task automatic push_random_run(input int boxes);
    longint c[3], v[3], lo[3], hi[3], span;
    span = radius_q < 1024 ? 1024 : (radius_q > 64'd1 << 24 ? 64'd1 << 24 : radius_q);
    for (int i = 0; i < 3; i++) begin
      c[i] = longint'($signed($urandom_range(0, 8))) * span - 4 * span
             + longint'($urandom_range(0, 1000));
      v[i] = rand32() >>> $urandom_range(0, 24);
    end
    push_request(ActLoad, c, v);
    for (int k = 0; k < boxes; k++) begin
      for (int i = 0; i < 3; i++) begin
        lo[i] = c[i] + (longint'($urandom_range(0, 6)) - 4) * span / 2
                - longint'($urandom_range(0, 2000));
        hi[i] = lo[i] + longint'($urandom_range(0, 4)) * span / 2
                + longint'($urandom_range(0, 2000));
      end
      if ($urandom_range(0, 15) == 0) begin
        lo[1] = hi[1] + 1000;  // inverted along y
      end
      push_request(ActBox, lo, hi);
    end
  endtask

  task automatic push_noise();
    longint f[3], s[3];
    for (int i = 0; i < 3; i++) begin
      f[i] = rand32();
      s[i] = rand32();
    end
    push_request(logic'($urandom_range(0, 1)), f, s);
  endtask

  task automatic run_phase(input int target);
    int start;
    start = n_loads + n_boxes;
    while (n_loads + n_boxes - start < target) begin
      if ($urandom_range(0, 5) == 0) push_noise();
      else push_random_run($urandom_range(1, 6));
    end
    wait (pending_requests.size() == 0 && expected_states.size() == 0);
    repeat (DrainCycles) @(posedge clk_i);
  endtask

  task automatic push_directed();
    longint mx, mn;
    mx = 64'sd2147483647;
    mn = -64'sd2147483648;
    // box ahead of any load: works on the reset state, center inside
    push_request(ActBox, '{-100, -100, -100}, '{100, 100, 100});
    // load below ground, falling
    push_request(ActLoad, '{0, -65536, 0}, '{1000, -50000, 0});
    // load above ground, no contact
    push_request(ActLoad, '{0, 655360, 0}, '{0, -65536, 0});
    // box far away: miss
    push_request(ActBox, '{6553600, 0, 0}, '{6600000, 100, 100});
    // box touching from the side, no inward velocity
    push_request(ActBox, '{20000, 600000, -100000}, '{300000, 700000, 100000});
    // box below the sphere lifting it up: grounded
    push_request(ActBox, '{-100000, 0, -100000}, '{100000, 640000, 100000});
    // inverted box
    push_request(ActBox, '{100000, 700000, 100000}, '{-100000, 600000, -100000});
    // box covering the whole range: center inside, up normal
    push_request(ActBox, '{mn, mn, mn}, '{mx, mx, mx});
    // extreme loads
    push_request(ActLoad, '{mn, mn, mn}, '{mn, mn, mn});
    // far box: squared distance saturates
    push_request(ActBox, '{mx, mx, mx}, '{mx, mx, mx});
    push_request(ActLoad, '{mx, mx, mx}, '{mx, mx, mx});
    push_request(ActBox, '{mn, mn, mn}, '{mn, mn, mn});
    push_request(ActBox, '{mx - 1000, mx - 1000, mx - 1000}, '{mx, mx, mx});
    push_request(ActLoad, '{-1, 0, 1}, '{-1, -1, -1});
    push_request(ActBox, '{0, 0, 0}, '{0, 0, 0});
  endtask

  initial begin
    rst_ni = 1'b0;
    psel = 1'b0; penable = 1'b0; pwrite = 1'b0; paddr = '0; pwdata = '0;
    errors = 0; n_loads = 0; n_boxes = 0; n_hits = 0; n_results = 0;
    quiet = 0;
    sph_grounded = 0;
    for (int i = 0; i < 3; i++) begin
      sph_ctr[i] = 0;
      sph_vel[i] = 0;
    end
    repeat (8) @(posedge clk_i);
    rst_ni <= 1'b1;

    // reset settings first
    push_directed();
    run_phase(90);
    reg_write(AddrRadius, 32'd0);
    reg_write(AddrLift, 32'd0);
    push_directed();
    run_phase(80);
    reg_write(AddrRadius, 32'hFFFF_FFFF);
    reg_write(AddrLift, 32'h0000_FFFF);
    run_phase(80);
    reg_write(AddrRadius, 32'd65536);
    reg_write(AddrLift, 32'd100);
    run_phase(100);
    reg_write(AddrRadius, $urandom_range(1, 1 << 22));
    reg_write(AddrLift, $urandom_range(0, 65535));
    run_phase(90);
    quiet = 1;
    reg_write(AddrRadius, 32'd32768);
    reg_write(AddrLift, 32'd7);
    run_phase(80);

    $display("covered %0d loads and %0d box requests, %0d box contacts, 6 register settings",
             n_loads, n_boxes, n_hits);
    if (errors == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

endmodule
